@@ rtl/css_pkg.sv @@
package css_pkg;

  // Store geometry.
  localparam int Depth = 64;
  localparam int IDX_W = $clog2(Depth);
  localparam int CNT_W = $clog2(Depth + 1);
  localparam int VALUE_W = 32;

  // Command codes.
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_ADVANCE = 3'd1;
  localparam logic [2:0] CMD_INSERT  = 3'd2;
  localparam logic [2:0] CMD_ATTACH  = 3'd3;
  localparam logic [2:0] CMD_REMOVE  = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NO_CUR = 2'd2;

  // What every cell does with its entry at a clock edge.
  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_OPEN,
    SHIFT_CLOSE
  } shift_t;

  // Operation broadcast along the row of cells.
  typedef struct packed {
    shift_t              kind;
    logic [IDX_W-1:0]    pos;
    logic [VALUE_W-1:0]  value;
  } cell_op_t;

  // Request transaction.
  typedef struct packed {
    logic [2:0]          cmd;
    logic [31:0]         value;
  } req_t;

  // Response transaction.
  typedef struct packed {
    logic [1:0]          status;
    logic [6:0]          count;
    logic                has_current;
    logic [31:0]         current_value;
  } rsp_t;

endpackage

@@ rtl/css_cell.sv @@
module css_cell (
  input  logic                          clk,
  input  logic [css_pkg::IDX_W-1:0]     idx,
  input  css_pkg::cell_op_t             op,
  input  logic [css_pkg::VALUE_W-1:0]   left_data,
  input  logic [css_pkg::VALUE_W-1:0]   right_data,
  output logic [css_pkg::VALUE_W-1:0]   data
);

  logic [css_pkg::VALUE_W-1:0] data_next;

  // Open a gap at the position, or close the gap left by a removal.
  always_comb begin
    data_next = data;
    case (op.kind)
      css_pkg::SHIFT_OPEN: begin
        if (idx == op.pos) begin
          data_next = op.value;
        end else if (idx > op.pos) begin
          data_next = left_data;
        end
      end
      css_pkg::SHIFT_CLOSE: begin
        if (idx >= op.pos) begin
          data_next = right_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // Entry storage holds no reset value.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ rtl/css_chain.sv @@
module css_chain (
  input  logic                          clk,
  input  css_pkg::cell_op_t             op,
  input  logic [css_pkg::IDX_W-1:0]     rd_idx,
  output logic [css_pkg::VALUE_W-1:0]   rd_data
);

  logic [css_pkg::VALUE_W-1:0] cell_data [css_pkg::Depth];

  // Row of cells, each linked to its neighbors; the end cells see zero beyond the row.
  for (genvar i = 0; i < css_pkg::Depth; i++) begin : g_cell
    logic [css_pkg::VALUE_W-1:0] left_data;
    logic [css_pkg::VALUE_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == css_pkg::Depth - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    css_cell u_cell (
      .clk        (clk),
      .idx        (css_pkg::IDX_W'(i)),
      .op         (op),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i])
    );
  end

  // Select the entry under the cursor.
  assign rd_data = cell_data[rd_idx];

endmodule

@@ rtl/cursor_sequence_store_top.sv @@
// Ordered store of up to 64 entries with a cursor, built as a row of cells.
// A request transaction (req, req_valid, req_stall) carries a command and a
// value: start, advance, insert before the cursor (at the front if there is no
// current entry), attach after the cursor (at the end if none), or remove the
// entry at the cursor. Every request yields exactly one response transaction
// (rsp, rsp_valid, rsp_stall) with the status, the entry count, whether a
// current entry exists and its value. An accepted request updates all cells in
// parallel as it is taken, and its response is registered after it.
// Throughput: one request every cycle while the receiver takes each response.
// The cell shift is registered and the entry select under the cursor is combinational.
// While a response waits for the receiver, the next request is still taken and
// executed; req_stall rises only when an executed request has no room in the
// response register, so a stalled receiver holds back at most one request.
// Reset (rst, synchronous, active high) empties the store, puts the cursor at
// zero and clears all pending transactions; entry contents are not cleared.
module cursor_sequence_store_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  css_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output css_pkg::rsp_t   rsp
);

  logic [css_pkg::CNT_W-1:0]   count;
  logic [css_pkg::CNT_W-1:0]   count_next;
  logic [css_pkg::CNT_W-1:0]   cursor;
  logic [css_pkg::CNT_W-1:0]   cursor_next;
  logic [1:0]                  status;
  logic [1:0]                  status_next;
  logic                        pending;
  logic                        req_take;
  logic                        rsp_load;
  logic                        has_cur;
  logic                        full;
  logic                        new_cur;
  logic [css_pkg::CNT_W-1:0]   ins_pos;
  css_pkg::cell_op_t           op;
  logic [css_pkg::VALUE_W-1:0] rd_data;

  // Handshake: a request waits only while an executed one still needs the
  // response register.
  assign rsp_load  = pending && (!rsp_valid || !rsp_stall);
  assign req_stall = pending && !rsp_load;
  assign req_take  = req_valid && !req_stall;

  assign has_cur = cursor < count;
  assign full    = count >= css_pkg::CNT_W'(css_pkg::Depth);

  // Command decode: next cursor, count, status and the cell operation.
  always_comb begin
    cursor_next = cursor;
    count_next  = count;
    status_next = css_pkg::ST_DONE;
    ins_pos     = '0;
    op.kind     = css_pkg::SHIFT_HOLD;
    op.pos      = '0;
    op.value    = req.value[css_pkg::VALUE_W-1:0];
    case (req.cmd)
      css_pkg::CMD_START: begin
        cursor_next = '0;
      end
      css_pkg::CMD_ADVANCE: begin
        if (!has_cur) begin
          status_next = css_pkg::ST_NO_CUR;
        end else begin
          cursor_next = cursor + 1'b1;
        end
      end
      css_pkg::CMD_INSERT, css_pkg::CMD_ATTACH: begin
        if (full) begin
          status_next = css_pkg::ST_FULL;
        end else begin
          if (req.cmd == css_pkg::CMD_INSERT) begin
            ins_pos = has_cur ? cursor : '0;
          end else begin
            ins_pos = has_cur ? cursor + 1'b1 : count;
          end
          cursor_next = ins_pos;
          count_next  = count + 1'b1;
          op.kind     = css_pkg::SHIFT_OPEN;
          op.pos      = ins_pos[css_pkg::IDX_W-1:0];
        end
      end
      css_pkg::CMD_REMOVE: begin
        if (!has_cur) begin
          status_next = css_pkg::ST_NO_CUR;
        end else begin
          count_next = count - 1'b1;
          op.kind    = css_pkg::SHIFT_CLOSE;
          op.pos     = cursor[css_pkg::IDX_W-1:0];
        end
      end
      default: begin
        status_next = css_pkg::ST_DONE;
      end
    endcase
    if (!req_take) begin
      op.kind = css_pkg::SHIFT_HOLD;
    end
  end

  // Row of entry cells.
  css_chain u_chain (
    .clk     (clk),
    .op      (op),
    .rd_idx  (cursor[css_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Cursor, count, status and the executed-but-unreported flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor  <= '0;
      count   <= '0;
      status  <= css_pkg::ST_DONE;
      pending <= 1'b0;
    end else begin
      if (req_take) begin
        cursor  <= cursor_next;
        count   <= count_next;
        status  <= status_next;
        pending <= 1'b1;
      end else if (rsp_load) begin
        pending <= 1'b0;
      end
    end
  end

  assign new_cur = has_cur;

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status        <= status;
      rsp.count         <= 7'(count);
      rsp.has_current   <= new_cur;
      rsp.current_value <= new_cur ? 32'(rd_data) : '0;
    end
  end

endmodule
